>>> src/snbp_pkg.sv
package snbp_pkg;

  // Field and datapath widths
  localparam int FRAC_BITS = 16;
  localparam int SIG_SEGS  = 32;
  localparam int VAL_W     = 24;
  localparam int ACC_W     = 48;
  localparam int MUL_W     = 25;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int LR_W      = 21;
  localparam int IDX_W     = 6;
  localparam int DEPTH     = 64;
  localparam int KIND_W    = 2;
  localparam int ACT_W     = 3;

  localparam int ONE       = 1 << FRAC_BITS;
  localparam int LR_RESET  = 1 << (FRAC_BITS - 1);
  localparam int VAL_MAX   = (1 << (VAL_W - 1)) - 1;
  localparam int VAL_MIN   = -(1 << (VAL_W - 1));

  // Sigmoid segmentation over [-8, 8]
  localparam int X_SPAN    = 16 * ONE;
  localparam int X_LO      = -8 * ONE;
  localparam int X_HI      = 8 * ONE;
  localparam int SEG_SHIFT = $clog2(X_SPAN / SIG_SEGS);
  localparam int XS_W      = $clog2(X_SPAN) + 1;
  localparam int K_W       = XS_W - SEG_SHIFT;
  localparam int FR_W      = SEG_SHIFT + 1;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    logic clip;
    val_t val;
  } sat_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 3'd0,
    ACT_FWD   = 3'd1,
    ACT_OGRAD = 3'd2,
    ACT_HID   = 3'd3,
    ACT_UPD   = 3'd4
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_OUT    = 2'd0,
    KIND_GRAD   = 2'd1,
    KIND_WEIGHT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    MS_VW, MS_VO, MS_DER, MS_DG, MS_LV, MS_DGR, MS_SIG
  } mul_sel_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_LOAD, OP_ACC, OP_RED, OP_SIGA, OP_SIGF,
    OP_DIFF, OP_DRED, OP_GFIN, OP_LRED, OP_UFIN
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_RDW, S_FMUL, S_HMUL, S_ACC, S_RED, S_SIGA, S_SIGM,
    S_SIGF, S_DIFF, S_DMUL, S_DRED, S_GMUL, S_GFIN, S_LMUL, S_LRED,
    S_UMUL, S_UFIN
  } state_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    dp_op_e   op;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] in_action;
    logic [ACT_W-1:0] action;
    logic             last;
    logic             out_busy;
  } dp_sts_t;

  typedef val_t sig_tab_t [0:SIG_SEGS];

  // Drop FRAC_BITS fraction bits, round half up
  function automatic prod_t reduce(prod_t v);
    prod_t t;
    t = v + prod_t'(LR_RESET);
    return t >>> FRAC_BITS;
  endfunction

  // Clip to the signed value range
  function automatic sat_t sat_val(prod_t v);
    sat_t s;
    s.clip = 1'b0;
    s.val  = v[VAL_W-1:0];
    if (v > prod_t'(VAL_MAX)) begin
      s.clip = 1'b1;
      s.val  = val_t'(VAL_MAX);
    end else if (v < prod_t'(VAL_MIN)) begin
      s.clip = 1'b1;
      s.val  = val_t'(VAL_MIN);
    end
    return s;
  endfunction

  // Shift-subtract division, elaboration only
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    int i;
    q = 0;
    r = 0;
    for (i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid of a nonnegative fixed-point value, elaboration only
  function automatic longint unsigned sig_pos(longint unsigned a);
    longint unsigned y, t2, t3, t4, t5, e, den;
    int i;
    y  = (a << (32 - FRAC_BITS)) >> 6;
    t2 = (y * y) >> 32;
    t3 = (t2 * y) >> 32;
    t4 = (t3 * y) >> 32;
    t5 = (t4 * y) >> 32;
    e  = (64'd1 << 32) - y + t2 / 2 - t3 / 6 + t4 / 24 - t5 / 120;
    if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
    for (i = 0; i < 6; i++) e = (e * e) >> 32;
    den = (64'd1 << 32) + e;
    return udiv64((64'd1 << (32 + FRAC_BITS)) + (den >> 1), den);
  endfunction

  function automatic sig_tab_t build_sig_tab();
    sig_tab_t t;
    longint b;
    int k;
    for (k = 0; k <= SIG_SEGS; k++) begin
      b = longint'(X_LO) + (longint'(k) * X_SPAN) / SIG_SEGS;
      if (b < 0) t[k] = val_t'(longint'(ONE) - longint'(sig_pos(longint'(-b))));
      else       t[k] = val_t'(sig_pos(b));
    end
    return t;
  endfunction

  // Sigmoid at the segment ends
  localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

>>> src/sigmoid_neuron_backprop_unit.sv
// Accepts one item at a time through a single shared 25x25 multiplier.
// A load writes the weight store; a forward term reads its weight, then
// multiplies and accumulates; a hidden term multiplies and accumulates.
// A final term, gradient or update result waits in the output register.
// Reset clears the accumulator, activation and gradient and sets the learning
// rate to 0.5; the weight store holds nothing defined until loaded.
module sigmoid_neuron_backprop_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [snbp_pkg::ACT_W-1:0]       action_i,
  input  logic [snbp_pkg::IDX_W-1:0]       index_i,
  input  logic signed [snbp_pkg::VAL_W-1:0] value_i,
  input  logic signed [snbp_pkg::VAL_W-1:0] out_weight_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [snbp_pkg::KIND_W-1:0]      result_kind_o,
  output logic signed [snbp_pkg::VAL_W-1:0] result_value_o,
  output logic                             saturated_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [snbp_pkg::LR_W-1:0]        cfg_data_i
);

  snbp_pkg::dp_cmd_t cmd;
  snbp_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  snbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  snbp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .index_i        (index_i),
    .value_i        (value_i),
    .out_weight_i   (out_weight_i),
    .last_i         (last_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .result_kind_o  (result_kind_o),
    .result_value_o (result_value_o),
    .saturated_o    (saturated_o)
  );

endmodule

>>> src/snbp_ctrl.sv
module snbp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  snbp_pkg::dp_sts_t sts_i,
  output snbp_pkg::dp_cmd_t cmd_o
);

  snbp_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= snbp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      snbp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (sts_i.in_action)
            snbp_pkg::ACT_LOAD:  state_d = snbp_pkg::S_LOAD;
            snbp_pkg::ACT_FWD:   state_d = snbp_pkg::S_RDW;
            snbp_pkg::ACT_OGRAD: state_d = snbp_pkg::S_DIFF;
            snbp_pkg::ACT_HID:   state_d = snbp_pkg::S_HMUL;
            snbp_pkg::ACT_UPD:   state_d = snbp_pkg::S_LMUL;
            default:             state_d = snbp_pkg::S_IDLE;
          endcase
        end
      end
      snbp_pkg::S_LOAD: state_d = snbp_pkg::S_IDLE;
      snbp_pkg::S_RDW:  state_d = snbp_pkg::S_FMUL;
      snbp_pkg::S_FMUL: state_d = snbp_pkg::S_ACC;
      snbp_pkg::S_HMUL: state_d = snbp_pkg::S_ACC;
      snbp_pkg::S_ACC:  state_d = sts_i.last ? snbp_pkg::S_RED : snbp_pkg::S_IDLE;
      snbp_pkg::S_RED: begin
        state_d = (sts_i.action == snbp_pkg::ACT_FWD) ? snbp_pkg::S_SIGA
                                                      : snbp_pkg::S_DMUL;
      end
      snbp_pkg::S_SIGA: state_d = snbp_pkg::S_SIGM;
      snbp_pkg::S_SIGM: state_d = snbp_pkg::S_SIGF;
      snbp_pkg::S_DIFF: state_d = snbp_pkg::S_DMUL;
      snbp_pkg::S_DMUL: state_d = snbp_pkg::S_DRED;
      snbp_pkg::S_DRED: state_d = snbp_pkg::S_GMUL;
      snbp_pkg::S_GMUL: state_d = snbp_pkg::S_GFIN;
      snbp_pkg::S_LMUL: state_d = snbp_pkg::S_LRED;
      snbp_pkg::S_LRED: state_d = snbp_pkg::S_UMUL;
      snbp_pkg::S_UMUL: state_d = snbp_pkg::S_UFIN;
      snbp_pkg::S_SIGF, snbp_pkg::S_GFIN, snbp_pkg::S_UFIN: begin
        if (!sts_i.out_busy) state_d = snbp_pkg::S_IDLE;
      end
      default: state_d = snbp_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath; final states keep their product steady while waiting
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.op      = snbp_pkg::OP_NONE;
    cmd_o.mul_sel = snbp_pkg::MS_VW;
    unique case (state_q)
      snbp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = snbp_pkg::OP_CAPTURE;
      end
      snbp_pkg::S_LOAD: cmd_o.op      = snbp_pkg::OP_LOAD;
      snbp_pkg::S_FMUL: cmd_o.mul_sel = snbp_pkg::MS_VW;
      snbp_pkg::S_HMUL: cmd_o.mul_sel = snbp_pkg::MS_VO;
      snbp_pkg::S_ACC:  cmd_o.op      = snbp_pkg::OP_ACC;
      snbp_pkg::S_RED:  cmd_o.op      = snbp_pkg::OP_RED;
      snbp_pkg::S_SIGA: cmd_o.op      = snbp_pkg::OP_SIGA;
      snbp_pkg::S_SIGM: cmd_o.mul_sel = snbp_pkg::MS_SIG;
      snbp_pkg::S_DIFF: cmd_o.op      = snbp_pkg::OP_DIFF;
      snbp_pkg::S_DMUL: cmd_o.mul_sel = snbp_pkg::MS_DER;
      snbp_pkg::S_DRED: cmd_o.op      = snbp_pkg::OP_DRED;
      snbp_pkg::S_GMUL: cmd_o.mul_sel = snbp_pkg::MS_DG;
      snbp_pkg::S_LMUL: cmd_o.mul_sel = snbp_pkg::MS_LV;
      snbp_pkg::S_LRED: cmd_o.op      = snbp_pkg::OP_LRED;
      snbp_pkg::S_UMUL: cmd_o.mul_sel = snbp_pkg::MS_DGR;
      snbp_pkg::S_SIGF: begin
        cmd_o.mul_sel = snbp_pkg::MS_SIG;
        if (!sts_i.out_busy) cmd_o.op = snbp_pkg::OP_SIGF;
      end
      snbp_pkg::S_GFIN: begin
        cmd_o.mul_sel = snbp_pkg::MS_DG;
        if (!sts_i.out_busy) cmd_o.op = snbp_pkg::OP_GFIN;
      end
      snbp_pkg::S_UFIN: begin
        cmd_o.mul_sel = snbp_pkg::MS_DGR;
        if (!sts_i.out_busy) cmd_o.op = snbp_pkg::OP_UFIN;
      end
      default: cmd_o.op = snbp_pkg::OP_NONE;
    endcase
  end

endmodule

>>> src/snbp_dp.sv
module snbp_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  snbp_pkg::dp_cmd_t             cmd_i,
  output snbp_pkg::dp_sts_t             sts_o,
  input  logic [snbp_pkg::ACT_W-1:0]    action_i,
  input  logic [snbp_pkg::IDX_W-1:0]    index_i,
  input  logic signed [snbp_pkg::VAL_W-1:0] value_i,
  input  logic signed [snbp_pkg::VAL_W-1:0] out_weight_i,
  input  logic                          last_i,
  input  logic                          cfg_valid_i,
  input  logic [snbp_pkg::LR_W-1:0]     cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [snbp_pkg::KIND_W-1:0]   result_kind_o,
  output logic signed [snbp_pkg::VAL_W-1:0] result_value_o,
  output logic                          saturated_o
);

  // Item registers
  logic [snbp_pkg::ACT_W-1:0] action_q;
  logic [snbp_pkg::IDX_W-1:0] idx_q;
  snbp_pkg::val_t             value_q, ow_q;
  logic                       last_q;

  // Neuron state
  snbp_pkg::acc_t             acc_q;
  snbp_pkg::val_t             act_q, grad_q;
  logic                       run_clip_q;
  logic [snbp_pkg::LR_W-1:0]  lr_q;

  // Working registers
  snbp_pkg::val_t             rdata_q, tmp_q, deriv_q;
  snbp_pkg::val_t             seg_s0_q, seg_diff_q;
  logic [snbp_pkg::FR_W-1:0]  seg_frac_q;
  snbp_pkg::prod_t            prod_q;
  logic                       clip_q;

  // Output register
  logic                       out_valid_q;
  logic [snbp_pkg::KIND_W-1:0] kind_q;
  snbp_pkg::val_t             res_q;
  logic                       sat_q;

  snbp_pkg::val_t             mem [snbp_pkg::DEPTH];

  logic signed [snbp_pkg::MUL_W-1:0] mul_a, mul_b;
  snbp_pkg::prod_t            prod_d;
  logic signed [snbp_pkg::ACC_W:0] acc_sum;
  snbp_pkg::acc_t             acc_d;
  logic                       acc_clip;
  snbp_pkg::sat_t             red_s, diff_s, prod_s, upd_s;
  snbp_pkg::val_t             xc, sig_val;
  logic [snbp_pkg::XS_W-1:0]  xs;
  logic [snbp_pkg::K_W-1:0]   k_full, k;
  logic [snbp_pkg::FR_W-1:0]  frac;
  snbp_pkg::val_t             s0, s1, sdiff;
  logic                       emit;

  assign sts_o.in_action = action_i;
  assign sts_o.action    = action_q;
  assign sts_o.last      = last_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_sel)
      snbp_pkg::MS_VW: begin
        mul_a = snbp_pkg::MUL_W'(rdata_q);
        mul_b = snbp_pkg::MUL_W'(value_q);
      end
      snbp_pkg::MS_VO: begin
        mul_a = snbp_pkg::MUL_W'(value_q);
        mul_b = snbp_pkg::MUL_W'(ow_q);
      end
      snbp_pkg::MS_DER: begin
        mul_a = snbp_pkg::MUL_W'(act_q);
        mul_b = snbp_pkg::MUL_W'(snbp_pkg::ONE) - snbp_pkg::MUL_W'(act_q);
      end
      snbp_pkg::MS_DG: begin
        mul_a = snbp_pkg::MUL_W'(deriv_q);
        mul_b = snbp_pkg::MUL_W'(tmp_q);
      end
      snbp_pkg::MS_LV: begin
        mul_a = signed'({{(snbp_pkg::MUL_W - snbp_pkg::LR_W){1'b0}}, lr_q});
        mul_b = snbp_pkg::MUL_W'(value_q);
      end
      snbp_pkg::MS_DGR: begin
        mul_a = snbp_pkg::MUL_W'(tmp_q);
        mul_b = snbp_pkg::MUL_W'(grad_q);
      end
      snbp_pkg::MS_SIG: begin
        mul_a = snbp_pkg::MUL_W'(seg_diff_q);
        mul_b = signed'({{(snbp_pkg::MUL_W - snbp_pkg::FR_W){1'b0}}, seg_frac_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Saturating accumulate
  always_comb begin
    acc_sum  = (snbp_pkg::ACC_W + 1)'(acc_q) + (snbp_pkg::ACC_W + 1)'(prod_q);
    acc_clip = acc_sum[snbp_pkg::ACC_W] != acc_sum[snbp_pkg::ACC_W-1];
    acc_d    = acc_sum[snbp_pkg::ACC_W-1:0];
    if (acc_clip) begin
      acc_d = acc_sum[snbp_pkg::ACC_W] ? {1'b1, {(snbp_pkg::ACC_W-1){1'b0}}}
                                       : {1'b0, {(snbp_pkg::ACC_W-1){1'b1}}};
    end
  end

  // Reductions and clips
  always_comb begin
    red_s  = snbp_pkg::sat_val(snbp_pkg::reduce(snbp_pkg::prod_t'(acc_q)));
    diff_s = snbp_pkg::sat_val(snbp_pkg::prod_t'(value_q) - snbp_pkg::prod_t'(act_q));
    prod_s = snbp_pkg::sat_val(snbp_pkg::reduce(prod_q));
    upd_s  = snbp_pkg::sat_val(snbp_pkg::prod_t'(rdata_q) + snbp_pkg::reduce(prod_q));
  end

  // Sigmoid segment lookup
  always_comb begin
    xc = tmp_q;
    if (tmp_q < snbp_pkg::val_t'(snbp_pkg::X_LO)) xc = snbp_pkg::val_t'(snbp_pkg::X_LO);
    if (tmp_q > snbp_pkg::val_t'(snbp_pkg::X_HI)) xc = snbp_pkg::val_t'(snbp_pkg::X_HI);
    xs     = snbp_pkg::XS_W'(xc - snbp_pkg::val_t'(snbp_pkg::X_LO));
    k_full = xs[snbp_pkg::XS_W-1:snbp_pkg::SEG_SHIFT];
    k      = (k_full >= snbp_pkg::K_W'(snbp_pkg::SIG_SEGS))
             ? snbp_pkg::K_W'(snbp_pkg::SIG_SEGS - 1) : k_full;
    frac   = snbp_pkg::FR_W'(xs - (snbp_pkg::XS_W'(k) << snbp_pkg::SEG_SHIFT));
    s0     = snbp_pkg::SIG_TAB[k];
    s1     = snbp_pkg::SIG_TAB[k + snbp_pkg::K_W'(1)];
    sdiff  = (s1 > s0) ? s1 - s0 : '0;
    sig_val = seg_s0_q + snbp_pkg::val_t'(prod_q >>> snbp_pkg::SEG_SHIFT);
  end

  assign emit = (cmd_i.op == snbp_pkg::OP_SIGF) || (cmd_i.op == snbp_pkg::OP_GFIN) ||
                (cmd_i.op == snbp_pkg::OP_UFIN);

  // Neuron state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      act_q       <= '0;
      grad_q      <= '0;
      run_clip_q  <= 1'b0;
      lr_q        <= snbp_pkg::LR_W'(snbp_pkg::LR_RESET);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) lr_q <= cfg_data_i;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (cmd_i.op)
        snbp_pkg::OP_ACC: begin
          acc_q <= acc_d;
          if (acc_clip) run_clip_q <= 1'b1;
        end
        snbp_pkg::OP_RED: begin
          acc_q      <= '0;
          run_clip_q <= 1'b0;
        end
        snbp_pkg::OP_SIGF: act_q  <= sig_val;
        snbp_pkg::OP_GFIN: grad_q <= prod_s.val;
        default: ;
      endcase
    end
  end

  // Item capture, working registers and result
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (cmd_i.op)
      snbp_pkg::OP_CAPTURE: begin
        action_q <= action_i;
        idx_q    <= index_i;
        value_q  <= value_i;
        ow_q     <= out_weight_i;
        last_q   <= last_i;
      end
      snbp_pkg::OP_RED: begin
        tmp_q  <= red_s.val;
        clip_q <= run_clip_q | red_s.clip;
      end
      snbp_pkg::OP_SIGA: begin
        seg_s0_q   <= s0;
        seg_diff_q <= sdiff;
        seg_frac_q <= frac;
      end
      snbp_pkg::OP_DIFF: begin
        tmp_q  <= diff_s.val;
        clip_q <= diff_s.clip;
      end
      snbp_pkg::OP_DRED: deriv_q <= snbp_pkg::val_t'(snbp_pkg::reduce(prod_q));
      snbp_pkg::OP_LRED: begin
        tmp_q  <= prod_s.val;
        clip_q <= prod_s.clip;
      end
      snbp_pkg::OP_SIGF: begin
        kind_q <= snbp_pkg::KIND_OUT;
        res_q  <= sig_val;
        sat_q  <= clip_q;
      end
      snbp_pkg::OP_GFIN: begin
        kind_q <= snbp_pkg::KIND_GRAD;
        res_q  <= prod_s.val;
        sat_q  <= clip_q | prod_s.clip;
      end
      snbp_pkg::OP_UFIN: begin
        kind_q <= snbp_pkg::KIND_WEIGHT;
        res_q  <= upd_s.val;
        sat_q  <= clip_q | upd_s.clip;
      end
      default: ;
    endcase
  end

  // Weight store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == snbp_pkg::OP_LOAD) mem[idx_q] <= value_q;
    else if (cmd_i.op == snbp_pkg::OP_UFIN) mem[idx_q] <= upd_s.val;
    rdata_q <= mem[idx_q];
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign result_value_o = res_q;
  assign saturated_o    = sat_q;

endmodule

>>> tb/sv/sigmoid_neuron_backprop_unit_tb.sv
module sigmoid_neuron_backprop_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Actions that the block ignores
  localparam logic [snbp_pkg::ACT_W-1:0] ACT_SPARE_LO  = 3'd5;
  localparam logic [snbp_pkg::ACT_W-1:0] ACT_SPARE_MID = 3'd6;
  localparam logic [snbp_pkg::ACT_W-1:0] ACT_SPARE_HI  = 3'd7;

  localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint HALF_LSB = longint'(1) <<< (snbp_pkg::FRAC_BITS - 1);
  localparam int PHASE_ITEMS = 260;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic [snbp_pkg::ACT_W-1:0] act;
    logic [snbp_pkg::IDX_W-1:0] idx;
    logic signed [snbp_pkg::VAL_W-1:0] val;
    logic signed [snbp_pkg::VAL_W-1:0] ow;
    logic last;
    bit typed;
    snbp_pkg::kind_e ekind;
    logic signed [snbp_pkg::VAL_W-1:0] evalue;
    logic esat;
  } item_t;

  typedef struct {
    snbp_pkg::kind_e kind;
    logic signed [snbp_pkg::VAL_W-1:0] value;
    logic sat;
  } res_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid, in_ready_o;
  logic out_valid_o, out_ready;
  logic [snbp_pkg::KIND_W-1:0] result_kind_o;
  logic signed [snbp_pkg::VAL_W-1:0] result_value_o;
  logic saturated_o;
  logic cfg_valid, cfg_ready_o;
  logic [snbp_pkg::LR_W-1:0] cfg_data;

  item_t cur;
  bit calm;
  int hold;
  bit held;
  int in_cnt, out_cnt, cfg_cnt, err_cnt;
  res_t pending_res[$];
  item_t dir_q[$];
  bit written[snbp_pkg::DEPTH];

  // Mirror of the neuron state
  longint weight_mirror[snbp_pkg::DEPTH];
  longint acc_mirror, act_mirror, grad_mirror;
  longint unsigned lr_mirror = snbp_pkg::LR_RESET;
  bit run_clip, op_clip;

  sigmoid_neuron_backprop_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .action_i       (cur.act),
    .index_i        (cur.idx),
    .value_i        (cur.val),
    .out_weight_i   (cur.ow),
    .last_i         (cur.last),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .result_kind_o  (result_kind_o),
    .result_value_o (result_value_o),
    .saturated_o    (saturated_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("sigmoid_neuron_backprop_unit verification failed");
    $finish;
  end

  // Saturate, noting any clip
  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) begin
      op_clip = 1'b1;
      return lo;
    end
    if (v > hi) begin
      op_clip = 1'b1;
      return hi;
    end
    return v;
  endfunction

  // Round half up, drop the fraction bits
  function automatic longint rnd_q(longint v);
    return (v + HALF_LSB) >>> snbp_pkg::FRAC_BITS;
  endfunction

  function automatic longint sig_half(longint a);
    longint unsigned y, t2, t3, t4, t5, e, den;
    y  = (longint'(a) << (32 - snbp_pkg::FRAC_BITS)) >> 6;
    t2 = (y * y) >> 32;
    t3 = (t2 * y) >> 32;
    t4 = (t3 * y) >> 32;
    t5 = (t4 * y) >> 32;
    e  = (64'd1 << 32) - y + t2 / 2 - t3 / 6 + t4 / 24 - t5 / 120;
    if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
    for (int i = 0; i < 6; i++) e = (e * e) >> 32;
    den = (64'd1 << 32) + e;
    return longint'(((64'd1 << (32 + snbp_pkg::FRAC_BITS)) + den / 2) / den);
  endfunction

  function automatic longint sig_exact(longint x);
    if (x < 0) return longint'(snbp_pkg::ONE) - sig_half(-x);
    return sig_half(x);
  endfunction

  // Piecewise linear sigmoid over [-8, 8]
  function automatic longint sig_lin(longint x);
    longint lo, span, k, b0, b1, s0, s1;
    lo = -8 * longint'(snbp_pkg::ONE);
    span = 16 * longint'(snbp_pkg::ONE);
    if (x < lo) x = lo;
    if (x > -lo) x = -lo;
    k = ((x - lo) * snbp_pkg::SIG_SEGS) / span;
    if (k >= snbp_pkg::SIG_SEGS) k = snbp_pkg::SIG_SEGS - 1;
    b0 = lo + (k * span) / snbp_pkg::SIG_SEGS;
    b1 = lo + ((k + 1) * span) / snbp_pkg::SIG_SEGS;
    s0 = sig_exact(b0);
    s1 = sig_exact(b1);
    if (b1 <= b0 || s1 <= s0) return s0;
    return s0 + longint'((longint'(s1 - s0) * longint'(x - b0))
                         / longint'(b1 - b0));
  endfunction

  function automatic longint slope();
    return rnd_q(act_mirror * (longint'(snbp_pkg::ONE) - act_mirror));
  endfunction

  // Predict the result of one accepted item
  task automatic neuron_step(input item_t it, output bit has, output res_t r);
    longint v, ow, d, x, p;
    int unsigned i;
    v = longint'(it.val);
    ow = longint'(it.ow);
    i = it.idx;
    has = 1'b0;
    r.kind = snbp_pkg::KIND_OUT;
    r.value = '0;
    r.sat = 1'b0;
    case (it.act)
      snbp_pkg::ACT_LOAD: weight_mirror[i] = v;
      snbp_pkg::ACT_FWD, snbp_pkg::ACT_HID: begin
        op_clip = 1'b0;
        p = (it.act == snbp_pkg::ACT_FWD) ? v * weight_mirror[i] : v * ow;
        acc_mirror = clamp(acc_mirror + p, ACC_LO, ACC_HI);
        if (op_clip) run_clip = 1'b1;
        if (it.last) begin
          op_clip = run_clip;
          x = clamp(rnd_q(acc_mirror), snbp_pkg::VAL_MIN, snbp_pkg::VAL_MAX);
          acc_mirror = 0;
          run_clip = 1'b0;
          has = 1'b1;
          if (it.act == snbp_pkg::ACT_FWD) begin
            act_mirror = clamp(sig_lin(x), snbp_pkg::VAL_MIN, snbp_pkg::VAL_MAX);
            r.kind = snbp_pkg::KIND_OUT;
            r.value = act_mirror[snbp_pkg::VAL_W-1:0];
          end else begin
            grad_mirror = clamp(rnd_q(slope() * x), snbp_pkg::VAL_MIN, snbp_pkg::VAL_MAX);
            r.kind = snbp_pkg::KIND_GRAD;
            r.value = grad_mirror[snbp_pkg::VAL_W-1:0];
          end
          r.sat = op_clip;
        end
      end
      snbp_pkg::ACT_OGRAD: begin
        op_clip = 1'b0;
        d = clamp(v - act_mirror, snbp_pkg::VAL_MIN, snbp_pkg::VAL_MAX);
        grad_mirror = clamp(rnd_q(slope() * d), snbp_pkg::VAL_MIN, snbp_pkg::VAL_MAX);
        has = 1'b1;
        r.kind = snbp_pkg::KIND_GRAD;
        r.value = grad_mirror[snbp_pkg::VAL_W-1:0];
        r.sat = op_clip;
      end
      snbp_pkg::ACT_UPD: begin
        op_clip = 1'b0;
        d = clamp(rnd_q(longint'(lr_mirror) * v), snbp_pkg::VAL_MIN, snbp_pkg::VAL_MAX);
        d = rnd_q(d * grad_mirror);
        weight_mirror[i] = clamp(weight_mirror[i] + d, snbp_pkg::VAL_MIN,
                                 snbp_pkg::VAL_MAX);
        has = 1'b1;
        r.kind = snbp_pkg::KIND_WEIGHT;
        r.value = weight_mirror[i][snbp_pkg::VAL_W-1:0];
        r.sat = op_clip;
      end
      default: ;
    endcase
  endtask

  // Append an expected result
  function automatic void queue_res(input res_t r);
    pending_res = {pending_res, r};
  endfunction

  // Append a directed row
  function automatic void add_row(input item_t it);
    dir_q = {dir_q, it};
  endfunction

  // Accept, predict and check on the rising edge
  always @(posedge clk_i) begin
    res_t got, exp_r, pr;
    bit has;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) begin
        lr_mirror = cfg_data;
        cfg_cnt++;
      end
      if (out_valid_o && out_ready) begin
        got.kind = snbp_pkg::kind_e'(result_kind_o);
        got.value = result_value_o;
        got.sat = saturated_o;
        if (pending_res.size() == 0) begin
          $display("%0t: result with nothing expected: kind %0d value %0d sat %0d",
                   $time, result_kind_o, result_value_o, saturated_o);
          err_cnt++;
        end else begin
          exp_r = pending_res.pop_front();
          if (got.kind !== exp_r.kind || got.value !== exp_r.value
              || got.sat !== exp_r.sat) begin
            $display({"%0t: mismatch: expected kind %0d value %0d sat %0d,",
                      " got kind %0d value %0d sat %0d"},
                     $time, exp_r.kind, exp_r.value, exp_r.sat,
                     result_kind_o, result_value_o, saturated_o);
            err_cnt++;
          end
        end
        out_cnt++;
      end
      if (in_valid && in_ready_o) begin
        neuron_step(cur, has, pr);
        if (has) begin
          if (cur.typed) begin
            pr.kind = cur.ekind;
            pr.value = cur.evalue;
            pr.sat = cur.esat;
          end
          queue_res(pr);
        end
        in_cnt++;
      end
    end
  end

  // Receiver: random stalls, one long hold-off
  initial begin
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && out_cnt >= 150) begin
        held = 1'b1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ready = 1'b0;
      end else begin
        out_ready = calm || ($urandom_range(0, 99) >= 17);
      end
    end
  end

  function automatic logic signed [snbp_pkg::VAL_W-1:0] pick_val();
    int p;
    p = $urandom_range(0, 99);
    if (p < 5) return snbp_pkg::VAL_W'(snbp_pkg::VAL_MAX);
    if (p < 10) return snbp_pkg::VAL_W'(snbp_pkg::VAL_MIN);
    if (p < 55) begin
      return snbp_pkg::VAL_W'($signed($urandom_range(0, 4 * snbp_pkg::ONE))
                              - 2 * snbp_pkg::ONE);
    end
    return snbp_pkg::VAL_W'($urandom());
  endfunction

  // Random item, never reading a weight that was never loaded
  function automatic item_t rand_item();
    item_t it;
    int p;
    p = $urandom_range(0, 99);
    it.idx = snbp_pkg::IDX_W'($urandom());
    it.val = pick_val();
    it.ow = pick_val();
    it.last = ($urandom_range(0, 3) == 0);
    it.typed = 1'b0;
    it.ekind = snbp_pkg::KIND_OUT;
    it.evalue = '0;
    it.esat = 1'b0;
    if (p < 14) it.act = snbp_pkg::ACT_LOAD;
    else if (p < 50) it.act = snbp_pkg::ACT_FWD;
    else if (p < 60) it.act = snbp_pkg::ACT_OGRAD;
    else if (p < 80) it.act = snbp_pkg::ACT_HID;
    else if (p < 95) it.act = snbp_pkg::ACT_UPD;
    else it.act = snbp_pkg::ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    if ((it.act == snbp_pkg::ACT_FWD || it.act == snbp_pkg::ACT_UPD) && !written[it.idx])
      it.act = snbp_pkg::ACT_LOAD;
    if (it.act == snbp_pkg::ACT_LOAD) written[it.idx] = 1'b1;
    return it;
  endfunction

  task automatic send(input item_t it);
    int n;
    if (!calm && $urandom_range(0, 99) < 17) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    cur = it;
    in_valid = 1'b1;
    n = in_cnt;
    do @(negedge clk_i); while (in_cnt == n);
  endtask

  // Let every expected result arrive, then the tail of any silent item
  task automatic drain();
    in_valid = 1'b0;
    while (pending_res.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_rate(input logic [snbp_pkg::LR_W-1:0] lr);
    int n;
    cfg_data = lr;
    cfg_valid = 1'b1;
    n = cfg_cnt;
    do @(negedge clk_i); while (cfg_cnt == n);
    cfg_valid = 1'b0;
  endtask

  initial begin
    logic [snbp_pkg::LR_W-1:0] rates[5];
    rst_ni = 1'b0;
    in_valid = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    calm = 1'b0;
    cur = '{snbp_pkg::ACT_LOAD, 0, 0, 0, 0, 0, snbp_pkg::KIND_OUT, 0, 0};
    rates = '{21'd0, 21'd1048576, 21'd0, 21'd1, snbp_pkg::LR_W'(snbp_pkg::LR_RESET)};
    rates[2] = snbp_pkg::LR_W'($urandom_range(1, 1048575));

    // Directed rows: expected values typed in where obvious
    add_row('{snbp_pkg::ACT_OGRAD, 0, 24'sh7FFFFF, 0, 1, 1, snbp_pkg::KIND_GRAD, 0, 0});
    add_row('{snbp_pkg::ACT_LOAD, 0, 24'sh7FFFFF, 0, 0, 0, snbp_pkg::KIND_OUT, 0, 0});
    add_row('{snbp_pkg::ACT_UPD, 0, 24'sh7FFFFF, 0, 1, 1, snbp_pkg::KIND_WEIGHT,
              24'sh7FFFFF, 0});
    add_row('{snbp_pkg::ACT_LOAD, 63, 24'sh800000, 0, 0, 0, snbp_pkg::KIND_OUT, 0, 0});
    add_row('{snbp_pkg::ACT_LOAD, 1, 24'sh010000, 0, 0, 0, snbp_pkg::KIND_OUT, 0, 0});
    // accumulator driven into clipping, then the flag carried to the end of the run
    add_row('{snbp_pkg::ACT_FWD, 0, 24'sh7FFFFF, 0, 0, 0, snbp_pkg::KIND_OUT, 0, 0});
    add_row('{snbp_pkg::ACT_FWD, 63, 24'sh800000, 0, 0, 0, snbp_pkg::KIND_OUT, 0, 0});
    add_row('{snbp_pkg::ACT_FWD, 63, 24'sh800000, 0, 0, 0, snbp_pkg::KIND_OUT, 0, 0});
    add_row('{snbp_pkg::ACT_FWD, 1, 24'sh000000, 0, 1, 0, snbp_pkg::KIND_OUT, 0, 0});
    add_row('{snbp_pkg::ACT_OGRAD, 0, 24'sh000000, 0, 1, 0, snbp_pkg::KIND_OUT, 0, 0});
    add_row('{snbp_pkg::ACT_HID, 5, 24'sh7FFFFF, 24'sh800000, 1, 0, snbp_pkg::KIND_OUT,
              0, 0});
    add_row('{snbp_pkg::ACT_HID, 0, 24'sh010000, 24'sh010000, 0, 0, snbp_pkg::KIND_OUT,
              0, 0});
    add_row('{snbp_pkg::ACT_HID, 0, 24'shFF8000, 24'sh020000, 1, 0, snbp_pkg::KIND_OUT,
              0, 0});
    add_row('{snbp_pkg::ACT_UPD, 1, 24'sh800000, 0, 1, 0, snbp_pkg::KIND_OUT, 0, 0});
    add_row('{snbp_pkg::ACT_UPD, 63, 24'sh7FFFFF, 0, 1, 0, snbp_pkg::KIND_OUT, 0, 0});
    // ignored actions, on a weight never loaded
    add_row('{ACT_SPARE_LO, 2, 24'sh123456, 24'sh654321, 1, 0, snbp_pkg::KIND_OUT, 0, 0});
    add_row('{ACT_SPARE_MID, 2, 24'sh7FFFFF, 24'sh7FFFFF, 1, 0, snbp_pkg::KIND_OUT, 0, 0});
    add_row('{ACT_SPARE_HI, 2, 24'sh800000, 24'sh800000, 0, 0, snbp_pkg::KIND_OUT, 0, 0});
    // mixed run: a forward term closed by a hidden term
    add_row('{snbp_pkg::ACT_FWD, 1, 24'sh008000, 0, 0, 0, snbp_pkg::KIND_OUT, 0, 0});
    add_row('{snbp_pkg::ACT_HID, 0, 24'sh018000, 24'shFF0000, 1, 0, snbp_pkg::KIND_OUT,
              0, 0});
    add_row('{snbp_pkg::ACT_FWD, 1, 24'shFFFFFF, 0, 1, 0, snbp_pkg::KIND_OUT, 0, 0});
    add_row('{snbp_pkg::ACT_OGRAD, 0, 24'sh800000, 0, 1, 0, snbp_pkg::KIND_OUT, 0, 0});
    add_row('{snbp_pkg::ACT_UPD, 0, 24'sh800000, 0, 1, 0, snbp_pkg::KIND_OUT, 0, 0});
    written[0] = 1'b1;
    written[1] = 1'b1;
    written[63] = 1'b1;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_q[i]) send(dir_q[i]);
    drain();

    // Random phases, one per learning rate
    foreach (rates[p]) begin
      write_rate(rates[p]);
      calm = (p == 2);
      repeat (PHASE_ITEMS) send(rand_item());
      drain();
    end
    calm = 1'b0;

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Covered %0d items and %0d results over %0d learning rates, with stalls on both sides.",
             in_cnt, out_cnt, cfg_cnt + 1);
    if (err_cnt == 0 && pending_res.size() == 0) begin
      $display("sigmoid_neuron_backprop_unit verification clean");
    end else begin
      $display("sigmoid_neuron_backprop_unit verification failed");
    end
    $finish;
  end

endmodule
